// File: hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication whose consequent must hold in the next cycle
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/l2ta_pkg.sv
// constants and table generator for the log2 approximation
`default_nettype none

package l2ta_pkg;

  localparam int unsigned DefTableEntries = 2048;
  localparam int          ExpBias         = 127;
  localparam int          FracBits        = 48;
  localparam logic [31:0] ScaleReset      = 32'h3F80_0000;
  localparam logic [31:0] DefaultNan      = 32'h7FC0_0000;
  localparam logic [31:0] QuietBit        = 32'h0040_0000;
  localparam logic [30:0] InfMag          = 31'h7F80_0000;
  localparam logic [7:0]  ExpAllOnes      = 8'hFF;
  localparam real         InvLn2          = 1.0 / 0.69314718055994530942;

  // single-precision pattern nearest log2(1 + i * inv_n), natural log in double then one rounding
  function automatic logic [31:0] log2_entry(input int unsigned i, input real inv_n);
    real         m;
    real         d;
    logic [63:0] b;
    logic [22:0] man;
    logic        g;
    logic        st;
    logic        rup;
    logic [31:0] se;
    m = 1.0 + real'(i) * inv_n;
    d = $ln(m) * InvLn2;
    if (d == 0.0) begin
      return 32'h0;
    end
    b   = $realtobits(d);
    se  = 32'(b[62:52]) - 32'd1023 + 32'd127;
    man = b[51:29];
    g   = b[28];
    st  = |b[27:0];
    rup = g & (st | man[0]);
    return (se << 23) + 32'(man) + 32'(rup);
  endfunction

endpackage

`default_nettype wire

// File: hdl/log2_table_approximation.sv
// an input transaction reaches the output register through seven register stages,
//   the first loaded at the accepting edge
// throughput: one transaction per cycle; the whole pipe advances together and
//   holds while the output register waits on m_tready_i
// the table lookup is a registered rom read in the first stage
// reset: asynchronous, active low; clears the valid bits and sets the scale to 1.0
`default_nettype none
`include "assert_macros.svh"

module log2_table_approximation import l2ta_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DefTableEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,   // scale_factor
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [31:0] s_tdata_i,     // value_bits
  input  wire logic        s_tlast_i,     // end_of_block
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [31:0]      m_tdata_o,     // result_bits
  output logic             m_tlast_o      // last_out
);

  localparam int  IdxW       = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int  MulW       = 23 + $clog2(TABLE_ENTRIES + 1);
  localparam real InvEntries = 1.0 / real'(TABLE_ENTRIES);

  typedef logic [31:0] rom_t [TABLE_ENTRIES];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      r[i] = log2_entry(i, InvEntries);
    end
    return r;
  endfunction

  localparam rom_t RomInit = build_rom();

  logic [31:0] scale_q;
  logic        adv;
  logic        in_acc;

  assign adv        = !(m_tvalid_o && !m_tready_i);
  assign s_tready_o = adv;
  assign in_acc     = s_tvalid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // valid chain
  logic vld_a_q, vld_b_q, vld_c_q, vld_d_q, vld_e_q, vld_f_q, vld_g_q;
  logic lst_a_q, lst_b_q, lst_c_q, lst_d_q, lst_e_q, lst_f_q, lst_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
      vld_f_q <= 1'b0;
      vld_g_q <= 1'b0;
    end else if (adv) begin
      vld_a_q <= in_acc;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
      vld_e_q <= vld_d_q;
      vld_f_q <= vld_e_q;
      vld_g_q <= vld_f_q;
    end
  end

  // stage a: rom read
  logic [MulW-1:0] idx_prod;
  logic [IdxW-1:0] idx;
  logic [7:0]      exp_a_q;
  logic [31:0]     rom_a_q;

  assign idx_prod = MulW'(s_tdata_i[22:0]) * MulW'(TABLE_ENTRIES);
  assign idx      = idx_prod[23 +: IdxW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      exp_a_q <= s_tdata_i[30:23];
      rom_a_q <= RomInit[idx];
      lst_a_q <= s_tlast_i;
    end
  end

  // stage b: exact fixed-point sum of exponent and fraction
  logic [7:0]          sa;
  logic [FracBits-1:0] frac;
  logic [8:0]          e9;
  logic [57:0]         sum_fx;
  logic                sgn_b_q;
  logic [56:0]         mag_b_q;

  always_comb begin
    sa     = rom_a_q[30:23] - 8'd102;
    frac   = (rom_a_q[30:23] == 8'd0) ? '0
           : (FracBits'({1'b1, rom_a_q[22:0]}) << sa[5:0]);
    e9     = {1'b0, exp_a_q} - 9'(ExpBias);
    sum_fx = {e9[8], e9, 48'b0} + {10'b0, frac};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sgn_b_q <= sum_fx[57];
      mag_b_q <= sum_fx[57] ? ((~sum_fx[56:0]) + 57'd1) : sum_fx[56:0];
      lst_b_q <= lst_a_q;
    end
  end

  // stage c: leading-zero count of the sum
  logic [5:0]  lz_c;
  logic [5:0]  lz_c_q;
  logic [56:0] mag_c_q;
  logic        sgn_c_q;
  logic        zro_c_q;

  always_comb begin
    lz_c = 6'd0;
    for (int i = 0; i < 57; i++) begin
      if (mag_b_q[i]) lz_c = 6'(56 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lz_c_q  <= lz_c;
      mag_c_q <= mag_b_q;
      sgn_c_q <= sgn_b_q;
      zro_c_q <= (mag_b_q == '0);
      lst_c_q <= lst_b_q;
    end
  end

  // stage d: normalise and round the sum to single precision
  logic [56:0] nrm_d;
  logic [24:0] m25;
  logic        rup_d;
  logic [8:0]  ex_d;
  logic [23:0] mx_d_q;
  logic [8:0]  ex_d_q;
  logic        sgn_d_q;
  logic        zro_d_q;

  always_comb begin
    nrm_d = mag_c_q << lz_c_q;
    rup_d = nrm_d[32] & ((|nrm_d[31:0]) | nrm_d[33]);
    m25   = {1'b0, nrm_d[56:33]} + 25'(rup_d);
    ex_d  = 9'd8 - {3'b0, lz_c_q} + 9'(m25[24]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx_d_q  <= m25[24] ? m25[24:1] : m25[23:0];
      ex_d_q  <= ex_d;
      sgn_d_q <= sgn_c_q;
      zro_d_q <= zro_c_q;
      lst_d_q <= lst_c_q;
    end
  end

  // stage e: multiply by the scale, special cases resolved here
  logic        s_nan;
  logic        s_inf;
  logic [23:0] sm24;
  logic [8:0]  es;
  logic        sgn_e;
  logic [31:0] spec_val;
  logic        spec;
  logic [47:0] p_e_q;
  logic [10:0] ep_e_q;
  logic        sgn_e_q;
  logic        spec_e_q;
  logic [31:0] spv_e_q;

  always_comb begin
    s_nan = (scale_q[30:23] == ExpAllOnes) && (scale_q[22:0] != '0);
    s_inf = (scale_q[30:23] == ExpAllOnes) && (scale_q[22:0] == '0);
    sm24  = {(scale_q[30:23] != 8'd0), scale_q[22:0]};
    es    = ((scale_q[30:23] == 8'd0) ? 9'd1 : {1'b0, scale_q[30:23]}) - 9'(ExpBias);
    sgn_e = sgn_d_q ^ scale_q[31];
    spec  = s_nan || s_inf || zro_d_q || (sm24 == '0);
    if (s_nan) begin
      spec_val = scale_q | QuietBit;
    end else if (s_inf) begin
      spec_val = zro_d_q ? DefaultNan : {sgn_e, InfMag};
    end else begin
      spec_val = {sgn_e, 31'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_e_q    <= mx_d_q * sm24;
      ep_e_q   <= {{2{es[8]}}, es} + {{2{ex_d_q[8]}}, ex_d_q} - 11'd46;
      sgn_e_q  <= sgn_e;
      spec_e_q <= spec;
      spv_e_q  <= spec_val;
      lst_e_q  <= lst_d_q;
    end
  end

  // stage f: leading-zero count of the product
  logic [5:0]  lz_f;
  logic [5:0]  lz_f_q;
  logic [47:0] p_f_q;
  logic [10:0] ep_f_q;
  logic        sgn_f_q;
  logic        spec_f_q;
  logic [31:0] spv_f_q;

  always_comb begin
    lz_f = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p_e_q[i]) lz_f = 6'(47 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lz_f_q   <= lz_f;
      p_f_q    <= p_e_q;
      ep_f_q   <= ep_e_q;
      sgn_f_q  <= sgn_e_q;
      spec_f_q <= spec_e_q;
      spv_f_q  <= spv_e_q;
      lst_f_q  <= lst_e_q;
    end
  end

  // stage g: normalise, subnormal shift, round to nearest even, select overflow or special result
  logic signed [11:0] biased;
  logic [47:0]        nrm_g;
  logic [11:0]        rs_full;
  logic [4:0]         rs;
  logic [79:0]        ext;
  logic [7:0]         bfield;
  logic               rup_g;
  logic [31:0]        packed_g;
  logic [31:0]        res_g;
  logic [31:0]        res_g_q;

  always_comb begin
    biased  = $signed({ep_f_q[10], ep_f_q}) + 12'sd174 - $signed({6'b0, lz_f_q});
    nrm_g   = p_f_q << lz_f_q;
    rs_full = 12'd1 - biased;
    if (biased >= 12'sd1) begin
      rs     = 5'd0;
      bfield = biased[7:0];
    end else begin
      rs     = (rs_full > 12'd26) ? 5'd26 : rs_full[4:0];
      bfield = 8'd1;
    end
    ext      = {nrm_g, 32'b0} >> rs;
    rup_g    = ext[55] & ((|ext[54:0]) | ext[56]);
    packed_g = {1'b0, bfield - 8'd1, 23'b0} + {8'b0, ext[79:56]} + 32'(rup_g);
    if (spec_f_q) begin
      res_g = spv_f_q;
    end else if (biased >= 12'sd255) begin
      res_g = {sgn_f_q, InfMag};
    end else begin
      res_g = {sgn_f_q, packed_g[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_g_q <= res_g;
      lst_g_q <= lst_f_q;
    end
  end

  assign m_tvalid_o = vld_g_q;
  assign m_tdata_o  = res_g_q;
  assign m_tlast_o  = lst_g_q;

  `CHK_ASSERT(a_nan_scale_quiet,
    (m_tvalid_o && scale_q[30:23] == ExpAllOnes && scale_q[22:0] != '0) |-> (m_tdata_o[30:22] == 9'h1FF),
    "nan scale did not give a quiet nan")
  `CHK_ASSERT(a_sum_normalised, (vld_d_q && !zro_d_q) |-> mx_d_q[23],
    "rounded sum mantissa lost its leading one")
  `CHK_NEXT(a_prod_nonzero, (adv && vld_d_q && !zro_d_q && sm24 != '0 && !s_nan && !s_inf),
    (p_e_q != '0 && !spec_e_q), "ordinary product came out zero or special")

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for the table-based log2 approximation
`default_nettype none

module tb import l2ta_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumEntries = 2048;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 20;

  typedef struct packed {
    logic [31:0] bits;
    logic        last;
  } log_result_t;

  typedef struct {
    logic [31:0] value;
    logic        last;
    bit          known;
    logic [31:0] result;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [31:0] s_tdata_i;
  logic        s_tlast_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [31:0] m_tdata_o;
  logic        m_tlast_o;

  log2_table_approximation i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  logic [31:0]  frac_table [NumEntries];
  logic [31:0]  scale_bits;
  log_result_t  pending_logs[$];
  stim_row_t    typed_rows[$];
  logic [31:0]  typed_results[$];
  bit           typed_flags[$];
  int unsigned  sent_cnt;
  int unsigned  recv_cnt;
  int unsigned  fail_cnt;
  int unsigned  cycle_cnt;
  bit           idle_on;

  // double to single, round to nearest even, subnormals and overflow included
  function automatic logic [31:0] to_single(input real d);
    logic [63:0] b;
    logic        sgn;
    int          ex;
    int          se;
    int          sh;
    logic [63:0] sig;
    logic [63:0] q;
    logic        g;
    logic        st;
    logic [31:0] r;
    b   = $realtobits(d);
    sgn = b[63];
    if (b[62:52] == 11'h7FF) begin
      return {sgn, 31'h7F80_0000};
    end
    if (b[62:52] == 11'h0) begin
      return {sgn, 31'h0};
    end
    ex  = int'(b[62:52]) - 1023;
    se  = ex + 127;
    sig = {11'h0, 1'b1, b[51:0]};
    if (se >= 255) begin
      return {sgn, 31'h7F80_0000};
    end
    if (se >= 1) begin
      g  = b[28];
      st = |b[27:0];
      r  = {1'b0, 8'(se), b[51:29]};
      r  = r + 32'(g & (st | b[29]));
      if (r[30:23] == 8'hFF) begin
        r = {1'b0, 31'h7F80_0000};
      end
      return {sgn, r[30:0]};
    end
    sh = -ex - 97;
    if (sh > 60) begin
      return {sgn, 31'h0};
    end
    q  = sig >> sh;
    g  = sig[sh-1];
    st = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
    q  = q + 64'(g & (st | q[0]));
    return {sgn, q[30:0]};
  endfunction

  function automatic real to_double(input logic [31:0] f);
    real v;
    if (f[30:23] == 8'hFF) begin
      return $bitstoreal({f[31], 11'h7FF, 52'h0});
    end
    if (f[30:23] == 8'h0) begin
      v = real'(f[22:0]) * (2.0 ** -149);
      return f[31] ? -v : v;
    end
    return $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'h0});
  endfunction

  // log2(m) on [1,2) by the atanh series
  function automatic real unit_log2(input real m);
    real t;
    real t2;
    real term;
    real acc;
    t    = (m - 1.0) / (m + 1.0);
    t2   = t * t;
    term = t;
    acc  = 0.0;
    for (int k = 0; k < 40; k++) begin
      acc  = acc + term / real'(2 * k + 1);
      term = term * t2;
    end
    return 2.0 * acc / 0.69314718055994530942;
  endfunction

  function automatic log_result_t predict_log(input logic [31:0] v, input logic last);
    log_result_t res;
    int          ex;
    logic [31:0] sum;
    ex  = int'(v[30:23]) - 127;
    sum = to_single(real'(ex) + to_double(frac_table[v[22:12]]));
    res.last = last;
    if (scale_bits[30:23] == 8'hFF && scale_bits[22:0] != 23'h0) begin
      res.bits = scale_bits | QuietBit;
    end else if (scale_bits[30:0] == InfMag && sum[30:0] == 31'h0) begin
      res.bits = DefaultNan;
    end else begin
      res.bits = to_single(to_double(sum) * to_double(scale_bits));
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 5))
      0:       v[30:23] = 8'(127 + $urandom_range(0, 6) - 3);
      1:       v[30:23] = 8'($urandom_range(0, 1) ? 8'h00 : 8'hFF);
      2:       v[22:0]  = 23'($urandom_range(0, 3)) << 12;
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    log_result_t exp_log;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
    if (rst_ni && s_tvalid_i && s_tready_o) begin
      pending_logs.push_back(predict_log(s_tdata_i, s_tlast_i));
      sent_cnt = sent_cnt + 1;
    end
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      recv_cnt = recv_cnt + 1;
      if (pending_logs.size() == 0) begin
        $error("unexpected result transaction: result_bits %h", m_tdata_o);
        fail_cnt = fail_cnt + 1;
      end else begin
        exp_log = pending_logs.pop_front();
        if (typed_flags.size() != 0) begin
          if (typed_flags.pop_front() && typed_results[0] != exp_log.bits) begin
            $error("result_bits: typed %h, predicted %h", typed_results[0], exp_log.bits);
            fail_cnt = fail_cnt + 1;
          end
          void'(typed_results.pop_front());
        end
        if (m_tdata_o !== exp_log.bits) begin
          $error("result_bits: expected %h, actual %h", exp_log.bits, m_tdata_o);
          fail_cnt = fail_cnt + 1;
        end
        if (m_tlast_o !== exp_log.last) begin
          $error("last_out: expected %b, actual %b", exp_log.last, m_tlast_o);
          fail_cnt = fail_cnt + 1;
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    int unsigned stall;
    m_tready_i = 1'b0;
    stall      = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        stall = stall - 1;
      end else begin
        m_tready_i <= 1'b1;
        if (m_tvalid_o) begin
          stall = idle_on ? $urandom_range(0, 5) : 0;
        end
      end
    end
  end

  task automatic send_value(input logic [31:0] v, input logic last);
    int unsigned gap;
    int unsigned target;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    target = sent_cnt + 1;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= v;
    s_tlast_i  <= last;
    do @(negedge clk_i); while (sent_cnt < target);
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    while (pending_logs.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_scale(input logic [31:0] s);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= s;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    scale_bits = s;
  endtask

  initial begin
    logic [31:0] scale_set[$];
    stim_row_t   row;
    for (int i = 0; i < NumEntries; i++) begin
      frac_table[i] = to_single(unit_log2(1.0 + real'(i) / real'(NumEntries)));
    end
    scale_bits  = ScaleReset;
    sent_cnt    = 0;
    recv_cnt    = 0;
    fail_cnt    = 0;
    cycle_cnt   = 0;
    idle_on     = 1'b1;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 32'h0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = 32'h0;
    s_tlast_i   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows at the reset scale of 1.0
    typed_rows = '{
      '{32'h3F80_0000, 1'b0, 1'b1, 32'h0000_0000},  // one: sum is zero
      '{32'h4000_0000, 1'b1, 1'b1, 32'h3F80_0000},
      '{32'h4080_0000, 1'b0, 1'b1, 32'h4000_0000},
      '{32'h3E80_0000, 1'b0, 1'b1, 32'hC000_0000},
      '{32'h0000_0000, 1'b1, 1'b1, 32'hC2FE_0000},  // zero: exponent -127
      '{32'h8000_0000, 1'b0, 1'b1, 32'hC2FE_0000},  // sign ignored
      '{32'h7F80_0000, 1'b0, 1'b1, 32'h4300_0000},  // infinity: exponent 128
      '{32'hFF80_0000, 1'b1, 1'b1, 32'h4300_0000},
      '{32'h7FC0_0000, 1'b0, 1'b0, 32'h0},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
      '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{32'h007F_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'h3F7F_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'h3FFF_FFFF, 1'b1, 1'b0, 32'h0},
      '{32'h3F80_1000, 1'b0, 1'b0, 32'h0},
      '{32'h7F7F_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'h5555_5555, 1'b1, 1'b0, 32'h0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0}
    };
    foreach (typed_rows[i]) begin
      row = typed_rows[i];
      typed_flags.push_back(row.known);
      typed_results.push_back(row.result);
      send_value(row.value, row.last);
    end

    // sender holds off until the pipe is empty
    wait_drained();

    scale_set = '{32'h3F80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h7F80_0000,
                  32'hFF80_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h8000_0000, 32'hC1A0_0000, 32'h0080_0000, $urandom()};
    foreach (scale_set[p]) begin
      write_scale(scale_set[p]);
      idle_on = (p % 4) != 3;
      for (int n = 0; n < 34; n++) begin
        send_value(($urandom_range(0, 9) == 0) ? 32'h3F80_0000 : rand_value(),
                   1'($urandom()));
      end
    end

    wait_drained();
    $display("covered %0d input transactions, %0d results, %0d scale settings",
             sent_cnt, recv_cnt, scale_set.size() + 1);
    $display("scales included max, min subnormal, zeros, infinities and nan");
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/l2ta_pkg.sv
hdl/log2_table_approximation.sv
tb/tb.sv
